// ===== src/cluster_chain_allocator_assert.svh =====
// Assertion macros used by the RTL of the cluster chain allocator.
`ifndef CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH
`define CLUSTER_CHAIN_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

`define CCA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define CCA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CCA_ASSERT_IMP(label, clk, rst, ante, cons)

`define CCA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/ccalloc_pkg.sv =====
package ccalloc_pkg;

   localparam int NUM_BLOCKS      = 1024;
   localparam int RESERVED_BLOCKS = 6;

   localparam int BLK_AW  = $clog2(NUM_BLOCKS);
   localparam int BLOCK_W = 16;
   localparam int FREED_W = 11;
   localparam int SKIP_W  = 10;
   localparam int STAT_W  = 2;
   localparam int OP_W    = 3;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;

   localparam logic [BLOCK_W-1:0] END_MARK     = 16'hFFFF;
   localparam logic [BLOCK_W-1:0] LINK_FREE    = 16'h0000;
   localparam logic [BLOCK_W-1:0] NUM_BLOCKS_B = BLOCK_W'(NUM_BLOCKS);
   localparam logic [FREED_W-1:0] NUM_BLOCKS_C = FREED_W'(NUM_BLOCKS);
   localparam logic [BLK_AW-1:0]  LAST_BLOCK   = BLK_AW'(NUM_BLOCKS - 1);

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC  = 3'd0,
      OP_APPEND = 3'd1,
      OP_FREE   = 3'd2,
      OP_SEEK   = 3'd3,
      OP_TRUNC  = 3'd4,
      OP_QUERY  = 3'd5
   } op_type;

   function automatic logic blk_in_range(input logic [BLOCK_W-1:0] b);
      return b < NUM_BLOCKS_B;
   endfunction

endpackage

// ===== src/ccalloc_ram.sv =====
module ccalloc_ram
   import ccalloc_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read of the entry being written returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cluster_chain_allocator.sv =====
// Cluster chain allocator: a used-block bitmap and a table of next-block links.
// Requests arrive on the req_ stream, one operation per transaction; each yields
// exactly one response transaction on the rsp_ stream, in order.
// After reset the block runs a clearing pass over all 1024 blocks that writes
// the reset contents of both memories; req_tready stays low until it is done.
// One request is handled at a time. After acceptance each request passes the
// dispatch state and then its memory walk before the response is offered: a bad
// block, an unused operation code or any operation that needs no memory read
// goes straight to output, a query reads the used bitmap once, an allocation
// steps past each used block in the lowest-free scan, and a chain walk (append,
// free, seek, truncate) follows one link per step, since each link read feeds
// the next read address of the single read port of the link memory. The worst
// case is an append on a long chain with a full bitmap.
// The response sits in an output register; a new request is accepted while an
// earlier response is still waiting, but the block holds its finished result
// until the receiver takes the previous one, so a stalled receiver stops the
// block after at most one further request.
`include "cluster_chain_allocator_assert.svh"

module cluster_chain_allocator
   import ccalloc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // op [2:0], block [18:3], skip [28:19], zero [31:29]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status [1:0], result_block [17:2], freed_count [28:18], is_used [29], zero [31:30]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_AWALK,
      S_LINK,
      S_FREE,
      S_TFIRST,
      S_THEAD,
      S_SEEK,
      S_QUERY,
      S_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [BLK_AW-1:0]     clr_ff, clr_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [BLOCK_W-1:0]    blk_ff, blk_in;
   logic [SKIP_W-1:0]     skip_ff, skip_in;
   logic [BLOCK_W-1:0]    cur_ff, cur_in;
   logic [FREED_W-1:0]    steps_ff, steps_in;
   logic [BLK_AW-1:0]     scan_ff, scan_in;
   logic                  tail_ff, tail_in;
   status_type            status_ff, status_in;
   logic [BLOCK_W-1:0]    res_ff, res_in;
   logic [FREED_W-1:0]    freed_ff, freed_in;
   logic                  used_ff, used_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic                  link_we;
   logic [BLK_AW-1:0]     link_waddr;
   logic [BLOCK_W-1:0]    link_wdata;
   logic [BLK_AW-1:0]     link_raddr;
   logic [BLOCK_W-1:0]    link_rdata;
   logic                  used_we;
   logic [BLK_AW-1:0]     used_waddr;
   logic [0:0]            used_wdata;
   logic [BLK_AW-1:0]     used_raddr;
   logic [0:0]            used_rdata;

   logic                  reserved;
   logic [FREED_W-1:0]    steps_nx;
   logic [FREED_W-1:0]    freed_nx;
   logic [SKIP_W-1:0]     skip_nx;
   state_type             free_done;

   ccalloc_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (BLOCK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   ccalloc_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (1)
   ) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_waddr),
      .wr_data (used_wdata),
      .rd_addr (used_raddr),
      .rd_data (used_rdata)
   );

   assign reserved  = 32'(clr_ff) < RESERVED_BLOCKS;
   assign steps_nx  = steps_ff + 1'b1;
   assign freed_nx  = freed_ff + 1'b1;
   assign skip_nx   = skip_ff - 1'b1;
   assign free_done = (op_type'(op_ff) == OP_TRUNC) ? S_THEAD : S_OUT;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      skip_in       = skip_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      scan_in       = scan_ff;
      tail_in       = tail_ff;
      status_in     = status_ff;
      res_in        = res_ff;
      freed_in      = freed_ff;
      used_in       = used_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      link_we    = 1'b0;
      link_waddr = cur_ff[BLK_AW-1:0];
      link_wdata = LINK_FREE;
      link_raddr = link_rdata[BLK_AW-1:0];
      used_we    = 1'b0;
      used_waddr = scan_ff;
      used_wdata = 1'b0;
      used_raddr = scan_ff + 1'b1;

      case (state_ff)
         S_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = clr_ff;
            link_wdata = reserved ? END_MARK : LINK_FREE;
            used_we    = 1'b1;
            used_waddr = clr_ff;
            used_wdata = reserved;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == LAST_BLOCK) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[OP_W-1:0];
               blk_in   = req_tdata[OP_W +: BLOCK_W];
               skip_in  = req_tdata[OP_W+BLOCK_W +: SKIP_W];
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in  = ST_OK;
            res_in     = END_MARK;
            freed_in   = '0;
            used_in    = 1'b0;
            tail_in    = 1'b0;
            steps_in   = '0;
            scan_in    = '0;
            cur_in     = blk_ff;
            link_raddr = blk_ff[BLK_AW-1:0];
            used_raddr = '0;
            case (op_type'(op_ff))
               OP_ALLOC: begin
                  state_in = S_SCAN;
               end
               OP_APPEND: begin
                  if (blk_ff == END_MARK) begin
                     state_in = S_SCAN;
                  end else if (!blk_in_range(blk_ff)) begin
                     status_in = ST_RANGE;
                     state_in  = S_OUT;
                  end else begin
                     state_in = S_AWALK;
                  end
               end
               OP_FREE: begin
                  if (blk_ff == END_MARK) begin
                     state_in = S_OUT;
                  end else if (!blk_in_range(blk_ff)) begin
                     status_in = ST_RANGE;
                     state_in  = S_OUT;
                  end else begin
                     state_in = S_FREE;
                  end
               end
               OP_SEEK: begin
                  if (blk_ff != END_MARK && !blk_in_range(blk_ff)) begin
                     status_in = ST_RANGE;
                     state_in  = S_OUT;
                  end else if (skip_ff == '0 || blk_ff == END_MARK) begin
                     res_in   = blk_ff;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_SEEK;
                  end
               end
               OP_TRUNC: begin
                  if (blk_ff == END_MARK) begin
                     state_in = S_OUT;
                  end else if (!blk_in_range(blk_ff)) begin
                     status_in = ST_RANGE;
                     state_in  = S_OUT;
                  end else begin
                     res_in   = blk_ff;
                     state_in = S_TFIRST;
                  end
               end
               OP_QUERY: begin
                  if (!blk_in_range(blk_ff)) begin
                     status_in = ST_RANGE;
                     state_in  = S_OUT;
                  end else begin
                     used_raddr = blk_ff[BLK_AW-1:0];
                     state_in   = S_QUERY;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_SCAN: begin
            if (!used_rdata[0]) begin
               used_we    = 1'b1;
               used_waddr = scan_ff;
               used_wdata = 1'b1;
               link_we    = 1'b1;
               link_waddr = scan_ff;
               link_wdata = END_MARK;
               res_in     = BLOCK_W'(scan_ff);
               state_in   = tail_ff ? S_LINK : S_OUT;
            end else if (scan_ff == LAST_BLOCK) begin
               status_in = ST_FULL;
               state_in  = S_OUT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_AWALK: begin
            if (link_rdata == END_MARK) begin
               tail_in    = 1'b1;
               scan_in    = '0;
               used_raddr = '0;
               state_in   = S_SCAN;
            end else begin
               steps_in = steps_nx;
               if (!blk_in_range(link_rdata) || steps_nx >= NUM_BLOCKS_C) begin
                  status_in = ST_RANGE;
                  state_in  = S_OUT;
               end else begin
                  cur_in = link_rdata;
               end
            end
         end
         S_LINK: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[BLK_AW-1:0];
            link_wdata = res_ff;
            state_in   = S_OUT;
         end
         S_FREE: begin
            link_we    = 1'b1;
            link_waddr = cur_ff[BLK_AW-1:0];
            link_wdata = LINK_FREE;
            used_we    = 1'b1;
            used_waddr = cur_ff[BLK_AW-1:0];
            used_wdata = 1'b0;
            freed_in   = freed_nx;
            if (link_rdata == END_MARK || freed_nx == NUM_BLOCKS_C) begin
               state_in = free_done;
            end else if (!blk_in_range(link_rdata)) begin
               status_in = ST_RANGE;
               state_in  = free_done;
            end else begin
               cur_in = link_rdata;
            end
         end
         S_TFIRST: begin
            if (link_rdata == END_MARK) begin
               state_in = S_THEAD;
            end else if (!blk_in_range(link_rdata)) begin
               status_in = ST_RANGE;
               state_in  = S_THEAD;
            end else begin
               cur_in   = link_rdata;
               state_in = S_FREE;
            end
         end
         S_THEAD: begin
            link_we    = 1'b1;
            link_waddr = res_ff[BLK_AW-1:0];
            link_wdata = END_MARK;
            state_in   = S_OUT;
         end
         S_SEEK: begin
            skip_in = skip_nx;
            if (skip_nx == '0 || link_rdata == END_MARK) begin
               res_in   = link_rdata;
               state_in = S_OUT;
            end else if (!blk_in_range(link_rdata)) begin
               status_in = ST_RANGE;
               state_in  = S_OUT;
            end else begin
               cur_in = link_rdata;
            end
         end
         S_QUERY: begin
            used_in  = used_rdata[0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {2'b00, used_ff, freed_ff, res_ff, status_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      blk_ff       <= blk_in;
      skip_ff      <= skip_in;
      cur_ff       <= cur_in;
      steps_ff     <= steps_in;
      scan_ff      <= scan_in;
      tail_ff      <= tail_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
      freed_ff     <= freed_in;
      used_ff      <= used_in;
      rsp_tdata_ff <= rsp_tdata_in;
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A taken response clears unless a new one is loaded in the same cycle.
   `CCA_ASSERT_NXT(a_rsp_drains, clock, reset,
      rsp_tvalid && rsp_tready && state_ff != S_OUT, !rsp_tvalid)
   `CCA_ASSERT_IMP(a_status_code, clock, reset,
      rsp_tvalid, rsp_tdata[1:0] != 2'd3)
   `CCA_ASSERT_IMP(a_freed_bound, clock, reset,
      rsp_tvalid, rsp_tdata[28:18] <= NUM_BLOCKS_C)
   `CCA_ASSERT_IMP(a_used_ok, clock, reset,
      rsp_tvalid && rsp_tdata[29], rsp_tdata[1:0] == ST_OK)
   `CCA_ASSERT_NXT(a_accept_dispatch, clock, reset,
      req_tvalid && req_tready, state_ff == S_DISPATCH)

endmodule
